[sv/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros shared by the SCC engine RTL
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge
`define TSC_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle
`define TSC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

[sv/tsc_pkg.sv]
// ---------------------------------------------------------------------------
// tsc_pkg
// Types and codes shared by the Tarjan SCC engine.
// ---------------------------------------------------------------------------
package tsc_pkg;

  // Fixed field widths
  localparam int VTX_W  = 10;
  localparam int OP_W   = 2;
  localparam int KIND_W = 3;
  localparam int SCC_W  = 10;

  // Input opcodes
  typedef enum logic [OP_W-1:0] {
    OP_START = 2'd0,
    OP_SUCC  = 2'd1,
    OP_DONE  = 2'd2
  } op_t;

  // Result kinds
  typedef enum logic [KIND_W-1:0] {
    K_PUSH     = 3'd0,
    K_LIVE     = 3'd1,
    K_DEAD     = 3'd2,
    K_POP      = 3'd3,
    K_MEMBER   = 3'd4,
    K_OVERFLOW = 3'd5,
    K_ORDER    = 3'd6
  } kind_t;

  // Per-vertex status
  typedef enum logic [1:0] {
    ST_UNKNOWN = 2'd0,
    ST_LIVE    = 2'd1,
    ST_DEAD    = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_LIVE,
    S_MEMB
  } state_t;

endpackage

[sv/tsc_ram.sv]
// ---------------------------------------------------------------------------
// tsc_ram
// Simple dual-port synchronous RAM: one write port, one read port with a
// registered read word (held while no read is issued).
// ---------------------------------------------------------------------------
module tsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, word held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sv/tarjan_scc_engine.sv]
// ---------------------------------------------------------------------------
// tarjan_scc_engine
// Iterative Tarjan SCC engine: vertex status table and DFS stack in RAM,
// the DFS top entry cached in registers, one result word per event or one
// per component member on a root pop.
// ---------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Word
//  in_     | input     | in_valid/in_stall  | opcode, vertex
//  out_    | output    | out_valid/out_stall| kind, vertex, scc number, top, empty, last
//
//  After reset the status table is swept to unknown, one vertex per cycle,
//  while in_stall stays high.
//  An event is accepted with a status/stack read, then executed; a live
//  successor adds a stack read of the lowlink at its position.
//  A root pop reads the stack top, then walks its members, one word each,
//  on the single stack read port; out_stall only delays the cycles that emit a word.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tarjan_scc_engine #(
  parameter int VERTEX_COUNT = 1024,
  parameter int STACK_DEPTH  = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input words
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [tsc_pkg::OP_W-1:0]    in_opcode,
  input  logic [tsc_pkg::VTX_W-1:0]   in_vertex,
  // result words
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [tsc_pkg::KIND_W-1:0]  out_kind,
  output logic [tsc_pkg::VTX_W-1:0]   out_vertex,
  output logic [tsc_pkg::SCC_W-1:0]   out_scc_number,
  output logic [tsc_pkg::VTX_W-1:0]   out_top_vertex,
  output logic                        out_search_empty,
  output logic                        out_last
);

  localparam int VW  = tsc_pkg::VTX_W;
  localparam int AW  = $clog2(VERTEX_COUNT);
  localparam int SW  = $clog2(STACK_DEPTH);
  localparam int PW  = $clog2(STACK_DEPTH + 1);
  localparam int SDW = 2 + SW;
  localparam int KDW = VW + SW + PW;

  // Controller and stack pointers (counts are position plus one)
  tsc_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_r, clr_nxt;
  logic [PW-1:0]   top_cnt_r, top_cnt_nxt;
  logic [PW-1:0]   dfs_cnt_r, dfs_cnt_nxt;
  logic [tsc_pkg::SCC_W-1:0] scc_cnt_r, scc_cnt_nxt;

  // Latched event
  logic [tsc_pkg::OP_W-1:0] op_r, op_nxt;
  logic [VW-1:0]            vtx_r, vtx_nxt;

  // Cached DFS top entry
  logic [VW-1:0] top_v_r, top_v_nxt;
  logic [SW-1:0] top_low_r, top_low_nxt;
  logic [PW-1:0] top_par_r, top_par_nxt;

  // Member walk and live check
  logic [SW-1:0] walk_i_r, walk_i_nxt;
  logic [SW-1:0] walk_end_r, walk_end_nxt;
  logic          live_ok_r, live_ok_nxt;

  // Output register
  logic                      out_valid_r, out_valid_nxt;
  logic [tsc_pkg::KIND_W-1:0] out_kind_r;
  logic [VW-1:0]             out_vertex_r;
  logic [tsc_pkg::SCC_W-1:0] out_scc_r;
  logic [VW-1:0]             out_top_r;
  logic                      out_empty_r;
  logic                      out_last_r;

  // Memory ports
  logic           st_we, st_re;
  logic [AW-1:0]  st_waddr, st_raddr;
  logic [SDW-1:0] st_wdata, st_rdata;
  logic           sk_we, sk_re;
  logic [SW-1:0]  sk_waddr, sk_raddr;
  logic [KDW-1:0] sk_wdata, sk_rdata;

  // Decoded words and conditions
  tsc_pkg::status_t st_state;
  logic [SW-1:0]    st_pos;
  logic [VW-1:0]    sk_v;
  logic [SW-1:0]    sk_low;
  logic [PW-1:0]    sk_par;
  logic [PW-1:0]    dfs_m1, top_m1, par_m1;
  logic [SW-1:0]    dfs_idx, top_idx, par_idx;
  logic             empty, in_range, sk_in_range, out_free;
  logic             is_visit, is_done, bad_order, full, is_root, walk_last;

  // Emitted word
  logic                       emit;
  tsc_pkg::kind_t             e_kind;
  logic [VW-1:0]              e_vtx;
  logic                       e_last;
  logic [SW-1:0]              new_low;

  tsc_ram #(.WIDTH(SDW), .DEPTH(VERTEX_COUNT)) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  tsc_ram #(.WIDTH(KDW), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk   (clk),
    .we    (sk_we),
    .waddr (sk_waddr),
    .wdata (sk_wdata),
    .re    (sk_re),
    .raddr (sk_raddr),
    .rdata (sk_rdata)
  );

  // Decode memory words and pointers
  assign st_state    = tsc_pkg::status_t'(st_rdata[SDW-1:SW]);
  assign st_pos      = st_rdata[SW-1:0];
  assign sk_v        = sk_rdata[KDW-1 -: VW];
  assign sk_low      = sk_rdata[PW +: SW];
  assign sk_par      = sk_rdata[PW-1:0];
  assign dfs_m1      = dfs_cnt_r - PW'(1);
  assign top_m1      = top_cnt_r - PW'(1);
  assign par_m1      = top_par_r - PW'(1);
  assign dfs_idx     = dfs_m1[SW-1:0];
  assign top_idx     = top_m1[SW-1:0];
  assign par_idx     = par_m1[SW-1:0];
  assign empty       = (dfs_cnt_r == '0);
  assign in_range    = 32'(vtx_r) < 32'(VERTEX_COUNT);
  assign sk_in_range = 32'(sk_v) < 32'(VERTEX_COUNT);
  assign out_free    = !out_valid_r || !out_stall;

  // Classify the latched event
  assign is_visit  = (op_r == tsc_pkg::OP_START) || (op_r == tsc_pkg::OP_SUCC);
  assign is_done   = (op_r == tsc_pkg::OP_DONE);
  assign bad_order = ((op_r == tsc_pkg::OP_START) != empty) || !in_range;
  assign full      = (top_cnt_r == PW'(STACK_DEPTH));
  assign is_root   = (top_low_r == dfs_idx);
  assign walk_last = (walk_i_r == walk_end_r);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tsc_pkg::S_CLEAR: begin
        if (clr_r == AW'(VERTEX_COUNT - 1)) begin
          state_nxt = tsc_pkg::S_IDLE;
        end
      end
      tsc_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = tsc_pkg::S_EXEC;
        end
      end
      tsc_pkg::S_EXEC: begin
        if (is_visit && !bad_order && st_state == tsc_pkg::ST_LIVE) begin
          state_nxt = tsc_pkg::S_LIVE;
        end else if (is_done && !empty && is_root) begin
          state_nxt = tsc_pkg::S_MEMB;
        end else if (out_free) begin
          state_nxt = tsc_pkg::S_IDLE;
        end
      end
      tsc_pkg::S_LIVE: begin
        if (out_free) begin
          state_nxt = tsc_pkg::S_IDLE;
        end
      end
      tsc_pkg::S_MEMB: begin
        if (out_free && walk_last) begin
          state_nxt = tsc_pkg::S_IDLE;
        end
      end
      default: state_nxt = tsc_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory accesses and emitted word
  always_comb begin
    clr_nxt      = clr_r;
    top_cnt_nxt  = top_cnt_r;
    dfs_cnt_nxt  = dfs_cnt_r;
    scc_cnt_nxt  = scc_cnt_r;
    op_nxt       = op_r;
    vtx_nxt      = vtx_r;
    top_v_nxt    = top_v_r;
    top_low_nxt  = top_low_r;
    top_par_nxt  = top_par_r;
    walk_i_nxt   = walk_i_r;
    walk_end_nxt = walk_end_r;
    live_ok_nxt  = live_ok_r;
    st_we        = 1'b0;
    st_waddr     = AW'(vtx_r);
    st_wdata     = {tsc_pkg::ST_UNKNOWN, SW'(0)};
    st_re        = 1'b0;
    st_raddr     = AW'(in_vertex);
    sk_we        = 1'b0;
    sk_waddr     = dfs_idx;
    sk_wdata     = {top_v_r, top_low_r, top_par_r};
    sk_re        = 1'b0;
    sk_raddr     = par_idx;
    emit         = 1'b0;
    e_kind       = tsc_pkg::K_ORDER;
    e_vtx        = '0;
    e_last       = 1'b1;
    new_low      = top_low_r;

    case (state_r)
      // Sweep the status table to unknown
      tsc_pkg::S_CLEAR: begin
        st_we    = 1'b1;
        st_waddr = clr_r;
        clr_nxt  = clr_r + AW'(1);
      end

      // Take an event, read its vertex status and the top's parent entry
      tsc_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_opcode;
          vtx_nxt = in_vertex;
          st_re   = 1'b1;
          sk_re   = 1'b1;
        end
      end

      tsc_pkg::S_EXEC: begin
        if (is_visit) begin
          if (bad_order) begin
            emit   = out_free;
            e_kind = tsc_pkg::K_ORDER;
            e_vtx  = vtx_r;
          end else if (st_state == tsc_pkg::ST_DEAD) begin
            emit   = out_free;
            e_kind = tsc_pkg::K_DEAD;
            e_vtx  = vtx_r;
          end else if (st_state == tsc_pkg::ST_LIVE) begin
            // fetch the lowlink at the live vertex's position
            live_ok_nxt = PW'(st_pos) < top_cnt_r;
            sk_re       = 1'b1;
            sk_raddr    = st_pos;
          end else if (full) begin
            emit   = out_free;
            e_kind = tsc_pkg::K_OVERFLOW;
            e_vtx  = vtx_r;
          end else if (out_free) begin
            // push the vertex on the stack and make it the DFS top
            emit        = 1'b1;
            e_kind      = tsc_pkg::K_PUSH;
            e_vtx       = vtx_r;
            sk_we       = 1'b1;
            sk_waddr    = top_cnt_r[SW-1:0];
            sk_wdata    = {vtx_r, top_cnt_r[SW-1:0], dfs_cnt_r};
            st_we       = 1'b1;
            st_waddr    = AW'(vtx_r);
            st_wdata    = {tsc_pkg::ST_LIVE, top_cnt_r[SW-1:0]};
            top_cnt_nxt = top_cnt_r + PW'(1);
            dfs_cnt_nxt = top_cnt_r + PW'(1);
            top_v_nxt   = vtx_r;
            top_low_nxt = top_cnt_r[SW-1:0];
            top_par_nxt = dfs_cnt_r;
          end
        end else if (is_done && !empty) begin
          if (is_root) begin
            // start the member walk from the stack top, parent becomes top
            scc_cnt_nxt  = scc_cnt_r + tsc_pkg::SCC_W'(1);
            dfs_cnt_nxt  = top_par_r;
            top_v_nxt    = sk_v;
            top_low_nxt  = sk_low;
            top_par_nxt  = sk_par;
            walk_end_nxt = dfs_idx;
            walk_i_nxt   = top_idx;
            sk_re        = 1'b1;
            sk_raddr     = top_idx;
          end else if (out_free) begin
            // pop to the parent and lower its lowlink
            emit        = 1'b1;
            e_kind      = tsc_pkg::K_POP;
            e_vtx       = top_v_r;
            dfs_cnt_nxt = top_par_r;
            if (top_par_r != '0) begin
              new_low     = (top_low_r <= sk_low) ? top_low_r : sk_low;
              sk_we       = 1'b1;
              sk_waddr    = par_idx;
              sk_wdata    = {sk_v, new_low, sk_par};
              top_v_nxt   = sk_v;
              top_low_nxt = new_low;
              top_par_nxt = sk_par;
            end
          end
        end else begin
          emit   = out_free;
          e_kind = tsc_pkg::K_ORDER;
          e_vtx  = '0;
        end
      end

      // Lower the top's lowlink from the live vertex's entry
      tsc_pkg::S_LIVE: begin
        if (out_free) begin
          emit   = 1'b1;
          e_kind = tsc_pkg::K_LIVE;
          e_vtx  = vtx_r;
          if (live_ok_r) begin
            new_low     = (sk_low <= top_low_r) ? sk_low : top_low_r;
            top_low_nxt = new_low;
            sk_we       = 1'b1;
            sk_waddr    = dfs_idx;
            sk_wdata    = {top_v_r, new_low, top_par_r};
          end
        end
      end

      // Emit one member per cycle while the output is free and mark it dead
      tsc_pkg::S_MEMB: begin
        if (out_free) begin
          emit     = 1'b1;
          e_kind   = tsc_pkg::K_MEMBER;
          e_vtx    = sk_v;
          e_last   = walk_last;
          st_we    = sk_in_range;
          st_waddr = AW'(sk_v);
          st_wdata = {tsc_pkg::ST_DEAD, SW'(0)};
          if (walk_last) begin
            top_cnt_nxt = PW'(walk_end_r);
          end else begin
            walk_i_nxt = walk_i_r - SW'(1);
            sk_re      = 1'b1;
            sk_raddr   = walk_i_r - SW'(1);
          end
        end
      end

      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Output word valid: set on emit, drop once taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tsc_pkg::S_CLEAR;
      clr_r       <= '0;
      top_cnt_r   <= '0;
      dfs_cnt_r   <= '0;
      scc_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      top_cnt_r   <= top_cnt_nxt;
      dfs_cnt_r   <= dfs_cnt_nxt;
      scc_cnt_r   <= scc_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    vtx_r      <= vtx_nxt;
    top_v_r    <= top_v_nxt;
    top_low_r  <= top_low_nxt;
    top_par_r  <= top_par_nxt;
    walk_i_r   <= walk_i_nxt;
    walk_end_r <= walk_end_nxt;
    live_ok_r  <= live_ok_nxt;
    if (emit) begin
      out_kind_r   <= e_kind;
      out_vertex_r <= e_vtx;
      out_last_r   <= e_last;
      out_scc_r    <= scc_cnt_nxt;
      out_top_r    <= (dfs_cnt_nxt != '0) ? top_v_nxt : '0;
      out_empty_r  <= (dfs_cnt_nxt == '0);
    end
  end

  assign in_stall         = (state_r != tsc_pkg::S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_vertex       = out_vertex_r;
  assign out_scc_number   = out_scc_r;
  assign out_top_vertex   = out_top_r;
  assign out_search_empty = out_empty_r;
  assign out_last         = out_last_r;

  // Checks
  `TSC_ASSERT(a_top_bound, top_cnt_r <= PW'(STACK_DEPTH), "stack count beyond depth")
  `TSC_ASSERT(a_dfs_below_top, dfs_cnt_r <= top_cnt_r, "DFS top above stack top")
  `TSC_ASSERT_NEXT(a_walk_end, (state_r == tsc_pkg::S_MEMB) && out_free && walk_last,
                   top_cnt_r == PW'(walk_end_r), "stack top not cut at component root")
  `TSC_ASSERT(a_single_last, !out_valid_r || out_kind_r == tsc_pkg::K_MEMBER || out_last_r,
              "non-member word without last")

endmodule
